/* hw/rtl/easing_curve_shaper_defines.svh */
// ----------------------------------------------------------------------------
// Easing curve shaper: assertion macros
// Shared concurrent assertion forms for the shaper's checker.
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_SHAPER_DEFINES_SVH
`define EASING_CURVE_SHAPER_DEFINES_SVH

// Condition that holds at every edge outside reset
`define ECS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must follow a trigger a fixed number of cycles later
`define ECS_ASSERT_AFTER(label, clk, rst_n, trig, n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##n (cond)) \
        else $error(msg);

`endif

/* hw/rtl/ecs_pkg.sv */
// ----------------------------------------------------------------------------
// Easing curve shaper package
// Shared widths, curve codes and the item handed to the overshoot stages.
// ----------------------------------------------------------------------------
package ecs_pkg;

    // Parameter defaults
    localparam int FRAC_BITS_DEF        = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Fixed field widths
    localparam int POS_W = 18;
    localparam int T_W   = 16;
    localparam int VAL_W = 17;
    localparam int MODE_W = 3;

    localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

    // Accepting edge to the edge that takes the result
    localparam int ECS_LATENCY = 6;

    // Curve codes; codes above the sine code also select sine
    typedef enum logic [MODE_W-1:0] {
        CM_LINEAR   = 3'd0,
        CM_EASE_IN  = 3'd1,
        CM_EASE_OUT = 3'd2,
        CM_IN_OUT   = 3'd3,
        CM_SINE     = 3'd4
    } t_curve_mode;

    // Curved value on its way to the overshoot blend
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             one;
        logic [T_W-1:0]   t;
        logic [VAL_W-1:0] e;
    } t_ovs_in;

endpackage

/* hw/rtl/ecs_sine_rom.sv */
// ----------------------------------------------------------------------------
// Sine quarter-wave table
// Constant table of sin(pi/2 * k / depth), two registered read ports.
// ----------------------------------------------------------------------------
module ecs_sine_rom #(
    parameter int FRAC_BITS        = ecs_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = ecs_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int AW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_addr,
    output logic [FRAC_BITS:0] o_lo,
    output logic [FRAC_BITS:0] o_hi
);
    import ecs_pkg::*;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor series for sine in Q2.30, evaluated at elaboration only
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 8; n++) begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if (n % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    logic [FRAC_BITS:0] rom_tab [0:SINE_TABLE_DEPTH];

    // Table contents, rounded to nearest and clamped at one
    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] S  = sine_q30(X);
        localparam logic [63:0] R0 = (S + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        localparam logic [63:0] R  = (R0 > (64'd1 << FRAC_BITS)) ?
                                     (64'd1 << FRAC_BITS) : R0;
        assign rom_tab[k] = R[FRAC_BITS:0];
    end

    // Neighbouring entries for interpolation, registered
    always_ff @(posedge i_clk) begin
        o_lo <= rom_tab[i_addr];
        o_hi <= rom_tab[i_addr + AW'(1)];
    end

endmodule

/* hw/rtl/ecs_overshoot.sv */
// ----------------------------------------------------------------------------
// Overshoot blend
// Where the curve lies above t, returns t + (e - t) * t; applies clipping.
// ----------------------------------------------------------------------------
module ecs_overshoot (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ecs_pkg::t_ovs_in           i_item,
    output logic                       o_strobe,
    output logic [ecs_pkg::VAL_W-1:0]  o_value
);
    import ecs_pkg::*;

    localparam int PROD_W = VAL_W + T_W;

    logic              r5_valid;
    logic              r5_zero;
    logic              r5_one;
    logic              r5_over;
    logic [T_W-1:0]    r5_t;
    logic [VAL_W-1:0]  r5_e;
    logic [PROD_W-1:0] r5_prod;

    logic [VAL_W-1:0]  n5_diff;
    logic              n5_over;
    logic [VAL_W:0]    n6_sum;
    logic [VAL_W-1:0]  n6_value;

    // Stage 5: excess over t, scaled by t
    assign n5_over = i_item.e > VAL_W'(i_item.t);
    assign n5_diff = i_item.e - VAL_W'(i_item.t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_zero <= i_item.zero;
        r5_one  <= i_item.one;
        r5_over <= n5_over;
        r5_t    <= i_item.t;
        r5_e    <= i_item.e;
        r5_prod <= PROD_W'(n5_diff) * PROD_W'(i_item.t);
    end

    // Stage 6: add back and clip
    assign n6_sum = (VAL_W + 1)'(r5_t) + (VAL_W + 1)'(r5_prod[PROD_W-1:16]);

    always_comb begin
        if (r5_zero) begin
            n6_value = '0;
        end else if (r5_one) begin
            n6_value = ONE_Q16;
        end else if (r5_over) begin
            n6_value = n6_sum[VAL_W-1:0];
        end else begin
            n6_value = r5_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_value <= n6_value;
    end

endmodule

/* hw/rtl/easing_curve_shaper.sv */
// Throughput: one item per clock; busy stays low, the pipeline never stalls.
// Six register stages set the latency; every stage takes a new item each cycle.
// Reset (synchronous, active low) clears the curve mode and all valid bits.
// ----------------------------------------------------------------------------
// Easing curve shaper
// Shapes a Q2.16 position by a selected easing curve into Q1.16.
// ----------------------------------------------------------------------------
module easing_curve_shaper #(
    parameter int FRAC_BITS        = ecs_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = ecs_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [ecs_pkg::MODE_W-1:0]        i_cfg_wdata,
    input  logic signed [ecs_pkg::POS_W-1:0]  i_position,
    output logic                              o_strobe,
    output logic [ecs_pkg::VAL_W-1:0]         o_shaped_value
);
    import ecs_pkg::*;

    localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int P_W    = T_W + AW;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int TAB_W  = FRAC_BITS + 1;
    localparam int DF_W   = TAB_W + T_W;
    localparam int SUM_W  = FRAC_BITS + VAL_W + 1;

    logic              accept;
    logic [MODE_W-1:0] r_curve_mode;

    // Stage 1 signals
    logic              n1_zero;
    logic              n1_one;
    logic [T_W-1:0]    n1_t;
    logic [VAL_W-1:0]  n1_m;
    logic [P_W-1:0]    n1_p;
    logic              r1_valid;
    logic              r1_zero;
    logic              r1_one;
    logic [T_W-1:0]    r1_t;
    logic [VAL_W-1:0]  r1_m;
    logic [AW-1:0]     r1_idx;
    logic [T_W-1:0]    r1_f;
    logic [MODE_W-1:0] r1_mode;

    // Stage 2 signals
    logic              r2_valid;
    logic              r2_zero;
    logic              r2_one;
    logic [T_W-1:0]    r2_t;
    logic [T_W-1:0]    r2_f;
    logic [MODE_W-1:0] r2_mode;
    logic [SQ_W-1:0]   r2_sq;
    logic [TAB_W-1:0]  tab_lo;
    logic [TAB_W-1:0]  tab_hi;

    // Stage 3 signals
    logic [TAB_W-1:0]  n3_d;
    logic [VAL_W-1:0]  n3_e;
    logic              n3_sine;
    logic              r3_valid;
    logic              r3_zero;
    logic              r3_one;
    logic              r3_sine;
    logic [T_W-1:0]    r3_t;
    logic [VAL_W-1:0]  r3_e;
    logic [TAB_W-1:0]  r3_a;
    logic [DF_W-1:0]   r3_df;

    // Stage 4 signals
    logic [SUM_W-1:0]  n4_sum;
    t_ovs_in           r4_item;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Curve mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= CM_LINEAR;
        end else if (i_cfg_we) begin
            r_curve_mode <= i_cfg_wdata;
        end
    end

    // Stage 1: clip decode, square operand, table position
    assign n1_zero = i_position[POS_W-1] || (i_position == '0);
    assign n1_one  = !n1_zero && (i_position[POS_W-2:T_W] != '0);
    assign n1_t    = i_position[T_W-1:0];
    assign n1_p    = P_W'(n1_t) * P_W'(SINE_TABLE_DEPTH);

    always_comb begin
        case (r_curve_mode)
            CM_EASE_OUT: n1_m = ONE_Q16 - VAL_W'(n1_t);
            CM_IN_OUT: begin
                if (n1_t[T_W-1]) begin
                    n1_m = VAL_W'(2 * 65536) - {n1_t, 1'b0};
                end else begin
                    n1_m = VAL_W'(n1_t);
                end
            end
            default: n1_m = VAL_W'(n1_t);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zero <= n1_zero;
        r1_one  <= n1_one;
        r1_t    <= n1_t;
        r1_m    <= n1_m;
        r1_idx  <= n1_p[P_W-1:T_W];
        r1_f    <= n1_p[T_W-1:0];
        r1_mode <= r_curve_mode;
    end

    // Stage 2: square, table read
    ecs_sine_rom #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .AW               (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r1_idx),
        .o_lo   (tab_lo),
        .o_hi   (tab_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_zero <= r1_zero;
        r2_one  <= r1_one;
        r2_t    <= r1_t;
        r2_f    <= r1_f;
        r2_mode <= r1_mode;
        r2_sq   <= SQ_W'(r1_m) * SQ_W'(r1_m);
    end

    // Stage 3: polynomial curves, interpolation step
    assign n3_d = (tab_hi > tab_lo) ? (tab_hi - tab_lo) : '0;

    always_comb begin
        n3_sine = 1'b0;
        case (r2_mode)
            CM_LINEAR:   n3_e = VAL_W'(r2_t);
            CM_EASE_IN:  n3_e = r2_sq[32:16];
            CM_EASE_OUT: n3_e = ONE_Q16 - r2_sq[32:16];
            CM_IN_OUT: begin
                if (r2_t[T_W-1]) begin
                    n3_e = ONE_Q16 - r2_sq[33:17];
                end else begin
                    n3_e = r2_sq[31:15];
                end
            end
            default: begin
                n3_e    = VAL_W'(r2_t);
                n3_sine = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_zero <= r2_zero;
        r3_one  <= r2_one;
        r3_sine <= n3_sine;
        r3_t    <= r2_t;
        r3_e    <= n3_e;
        r3_a    <= tab_lo;
        r3_df   <= DF_W'(n3_d) * DF_W'(r2_f);
    end

    // Stage 4: finish interpolation, pick the curve
    assign n4_sum = {r3_a, {T_W{1'b0}}} + SUM_W'(r3_df);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_item.valid <= 1'b0;
        end else begin
            r4_item.valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_item.zero <= r3_zero;
        r4_item.one  <= r3_one;
        r4_item.t    <= r3_t;
        r4_item.e    <= r3_sine ? n4_sum[FRAC_BITS +: VAL_W] : r3_e;
    end

    // Stages 5 and 6
    ecs_overshoot u_ovs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r4_item),
        .o_strobe (o_strobe),
        .o_value  (o_shaped_value)
    );

endmodule

/* hw/rtl/ecs_checker.sv */
// ----------------------------------------------------------------------------
// Easing curve shaper port checker
// Watches the top-level ports for busy, latency and clipping.
// ----------------------------------------------------------------------------
`include "easing_curve_shaper_defines.svh"

module ecs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [ecs_pkg::POS_W-1:0]  i_position,
    input  logic                              o_strobe,
    input  logic [ecs_pkg::VAL_W-1:0]         o_shaped_value
);
    import ecs_pkg::*;

    logic accept;
    logic pos_low;
    logic pos_high;

    assign accept   = start && !busy;
    assign pos_low  = i_position[POS_W-1] || (i_position == '0);
    assign pos_high = !pos_low && (i_position[POS_W-2:T_W] != '0);

    // The pipeline never holds items off
    `ECS_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy, "busy raised")

    // Every accepted item strobes once, after the fixed latency
    `ECS_ASSERT_AFTER(a_strobe_follows, i_clk, i_rst_n, accept, ECS_LATENCY, o_strobe, "result missing")
    `ECS_ASSERT_AFTER(a_no_extra, i_clk, i_rst_n, !accept, ECS_LATENCY, !o_strobe, "spurious result")

    // Clipped positions give the clip values
    `ECS_ASSERT_AFTER(a_clip_low, i_clk, i_rst_n, accept && pos_low, ECS_LATENCY, o_shaped_value == '0, "low clip wrong")
    `ECS_ASSERT_AFTER(a_clip_high, i_clk, i_rst_n, accept && pos_high, ECS_LATENCY, o_shaped_value == ONE_Q16, "high clip wrong")

endmodule

bind easing_curve_shaper ecs_checker u_ecs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_position     (i_position),
    .o_strobe       (o_strobe),
    .o_shaped_value (o_shaped_value)
);

/* dv/shaper_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve shaper checker
// Watches the item, configuration and result ports of the shaper, works out
// the shaped value of every accepted position and compares each strobed
// result in order with the oldest value still owed.
// ----------------------------------------------------------------------------
module shaper_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_cfg_we,
    input  logic [ecs_pkg::MODE_W-1:0]        i_cfg_wdata,
    input  logic signed [ecs_pkg::POS_W-1:0]  i_position,
    input  logic                              i_strobe,
    input  logic [ecs_pkg::VAL_W-1:0]         i_shaped_value,
    output int                                o_accepted,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_mismatches
);
    import ecs_pkg::*;

    localparam int               FRAC  = FRAC_BITS_DEF;
    localparam int               DEPTH = SINE_TABLE_DEPTH_DEF;
    localparam longint unsigned  UNIT  = 64'd65536;
    localparam longint unsigned  HALF_PI_Q30 = 64'd1686629713;
    localparam int               REPORT_MAX = 10;

    longint unsigned    sine_lut [0:DEPTH];
    logic [VAL_W-1:0]   owed_values [$];
    logic [MODE_W-1:0]  curve_mode_q;
    int                 n_accepted;
    int                 n_results;
    int                 n_bad;

    // sin(x) for x in Q2.30 on [0, pi/2], eight Taylor terms past the first
    function automatic longint unsigned quarter_sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              n;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    // Quarter-wave table, rounded to nearest and clamped at one
    initial begin
        longint unsigned x;
        longint unsigned r;
        for (int k = 0; k <= DEPTH; k++) begin
            x = (HALF_PI_Q30 * longint'(k)) / longint'(DEPTH);
            r = (quarter_sine_q30(x) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            if (r > (64'd1 << FRAC)) r = 64'd1 << FRAC;
            sine_lut[k] = r;
        end
    end

    // Shaped value of one position under one curve mode
    function automatic logic [VAL_W-1:0] shape_position(
        input logic signed [POS_W-1:0] pos,
        input logic [MODE_W-1:0]       mode
    );
        longint unsigned t, e, u, v, p, idx, frac, a, b, d, res;
        if (pos <= 0) return '0;
        t = longint'(pos);
        if (t >= UNIT) return ONE_Q16;
        case (mode)
            CM_LINEAR: begin
                e = t;
            end
            CM_EASE_IN: begin
                e = (t * t) >> 16;
            end
            CM_EASE_OUT: begin
                u = UNIT - t;
                e = UNIT - ((u * u) >> 16);
            end
            CM_IN_OUT: begin
                if (t < (UNIT >> 1)) begin
                    e = (t * t) >> 15;
                end else begin
                    v = 2 * UNIT - 2 * t;
                    e = UNIT - ((v * v) >> 17);
                end
            end
            default: begin
                // every code from the sine code upwards reads the table
                p    = t * longint'(DEPTH);
                idx  = p >> 16;
                frac = p & 64'hFFFF;
                if (idx >= DEPTH) idx = DEPTH - 1;
                a = sine_lut[idx];
                b = sine_lut[idx + 1];
                d = (b > a) ? b - a : 64'd0;
                e = ((a << 16) + d * frac) >> FRAC;
            end
        endcase
        // overshoot above the diagonal is scaled back by t
        if (e > t) begin
            res = t + (((e - t) * t) >> 16);
        end else begin
            res = e;
        end
        return res[VAL_W-1:0];
    endfunction

    task automatic report_fault(input string what, input logic [VAL_W-1:0] want,
                                input logic [VAL_W-1:0] got);
        n_bad++;
        if (n_bad <= REPORT_MAX) begin
            $display("%0t: %s shaped_value: expected %0d, got %0d", $realtime, what,
                     want, got);
        end
    endtask

    // Track the mode register, queue predictions, compare strobed results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            curve_mode_q = CM_LINEAR;
            owed_values.delete();
        end else begin
            if (i_strobe) begin
                n_results++;
                if (owed_values.size() == 0) begin
                    report_fault("unexpected", '0, i_shaped_value);
                end else if (owed_values[0] !== i_shaped_value) begin
                    report_fault("mismatch", owed_values.pop_front(), i_shaped_value);
                end else begin
                    void'(owed_values.pop_front());
                end
            end
            // an item taken at the same edge as a mode write sees the old mode
            if (i_start && !i_busy) begin
                n_accepted++;
                owed_values.push_back(shape_position(i_position, curve_mode_q));
            end
            if (i_cfg_we) curve_mode_q = i_cfg_wdata;
        end
        o_accepted   <= n_accepted;
        o_pending    <= owed_values.size();
        o_results    <= n_results;
        o_mismatches <= n_bad;
    end

    initial begin
        n_accepted   = 0;
        n_results    = 0;
        n_bad        = 0;
        curve_mode_q = CM_LINEAR;
        o_accepted   = 0;
        o_pending    = 0;
        o_results    = 0;
        o_mismatches = 0;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve shaper testbench
// Drives edge positions under every curve mode, then random positions in
// phases of random mode with random gaps and drains; the checker beside the
// block scores every result and the verdict is given here.
// ----------------------------------------------------------------------------
module tb_top;
    import ecs_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int N_MODES      = 1 << MODE_W;

    // Edge positions in groups of three, a group for each mode, modes taken in order
    localparam int EDGE_POS [24] = '{
        -131072, 0, 1,
        131071, 65536, 32767,
        32768, 65535, -1,
        32767, 32768, 32769,
        1, 65535, 64,
        65472, 65535, 16384,
        49152, 100, 65536,
        1, 32768, 131071
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_cfg_we;
    logic [MODE_W-1:0]        i_cfg_wdata;
    logic signed [POS_W-1:0]  i_position;
    logic                     o_strobe;
    logic [VAL_W-1:0]         o_shaped_value;

    int                       n_accepted;
    int                       n_pending;
    int                       n_results;
    int                       n_mismatches;
    int                       n_settings;
    logic [N_MODES-1:0]       modes_seen;
    int                       cycle_count;

    easing_curve_shaper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_position     (i_position),
        .o_strobe       (o_strobe),
        .o_shaped_value (o_shaped_value)
    );

    shaper_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_position     (i_position),
        .i_strobe       (o_strobe),
        .i_shaped_value (o_shaped_value),
        .o_accepted     (n_accepted),
        .o_pending      (n_pending),
        .o_results      (n_results),
        .o_mismatches   (n_mismatches)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("easing_curve_shaper verification failed");
            $finish;
        end
    end

    // Present one position at a falling edge and hold it until accepted
    task automatic send_position(input logic signed [POS_W-1:0] pos);
        int want;
        want = n_accepted + 1;
        start      <= 1'b1;
        i_position <= pos;
        do @(negedge i_clk); while (n_accepted != want);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait for every owed result
    task automatic drain_results();
        start <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_curve_mode(input logic [MODE_W-1:0] mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        modes_seen[mode] = 1'b1;
        n_settings++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Mostly inside (0, 1), then full range, edges and the ends of the curve
    function automatic logic signed [POS_W-1:0] pick_position();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 60) return POS_W'($urandom_range(1, 65535));
        if (r < 75) return POS_W'($urandom);
        if (r < 90) begin
            case ($urandom_range(0, 2))
                0:       base = 0;
                1:       base = 32768;
                default: base = 65536;
            endcase
            return POS_W'(base + int'($urandom_range(0, 8)) - 4);
        end
        if (r < 95) return POS_W'($urandom_range(1, 255));
        return POS_W'(65535 - int'($urandom_range(0, 255)));
    endfunction

    // Stimulus and verdict
    initial begin
        int  n_random;
        int  phase_len;
        bit  no_gaps;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_position  = '0;
        i_rst_n     = 1'b0;
        n_settings  = 0;
        modes_seen  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // edge positions under each mode in turn
        for (int m = 0; m < N_MODES; m++) begin
            drain_results();
            write_curve_mode(MODE_W'(m));
            for (int k = 0; k < 3; k++) send_position(POS_W'(EDGE_POS[m * 3 + k]));
        end

        // random phases, each under its own mode
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            drain_results();
            write_curve_mode(MODE_W'($urandom_range(0, N_MODES - 1)));
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 160);
            for (int k = 0; k < phase_len; k++) begin
                if (!no_gaps) idle_gap(pick_gap());
                if ($urandom_range(0, 149) == 0) drain_results();
                send_position(pick_position());
            end
            n_random += phase_len;
        end

        drain_results();
        repeat (ECS_LATENCY + 4) @(negedge i_clk);

        $display("Checked %0d shaped values from %0d positions over %0d mode settings",
                 n_results, n_accepted, n_settings);
        $display("Curve modes exercised (bit per mode): %b", modes_seen);
        if (n_mismatches == 0 && n_pending == 0) begin
            $display("easing_curve_shaper verification clean");
        end else begin
            $display("easing_curve_shaper verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ecs_pkg.sv
hw/rtl/ecs_sine_rom.sv
hw/rtl/ecs_overshoot.sv
hw/rtl/easing_curve_shaper.sv
hw/rtl/ecs_checker.sv
dv/shaper_checker.sv
dv/tb_top.sv
